// ===== hw/rtl/lpr_pkg.sv =====
// Package for the IPv4 longest-prefix route engine.
// Holds the beat that walks the cell chain, op and status codes and the prefix mask helper.
// No dependencies.
package lpr_pkg;

    localparam int LPR_ROUTES     = 64;
    localparam int LPR_INTERFACES = 8;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    localparam logic [2:0] ST_FORWARDED = 3'd0;
    localparam logic [2:0] ST_TTL_EXP   = 3'd1;
    localparam logic [2:0] ST_NO_ROUTE  = 3'd2;
    localparam logic [2:0] ST_ADDED     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // One beat in flight along the chain: the item plus what the cells have found so far.
    typedef struct packed {
        logic        vld;
        logic        op;
        logic [31:0] addr;       // prefix for add, destination for route
        logic [5:0]  len;        // saturated prefix length (add)
        logic        hop_given;
        logic [31:0] hop;
        logic [2:0]  port;       // already reduced to the interface count
        logic [7:0]  ttl;
        logic        hit;        // duplicate seen (add) or match found (route)
        logic        placed;     // entry written (add)
        logic [5:0]  best_len;
        logic        best_direct;
        logic [31:0] best_hop;
        logic [2:0]  best_port;
    } t_beat;

    // High-order mask of len ones; len 0 gives all zero, 32 gives all ones.
    function automatic logic [31:0] top_mask(input logic [5:0] len);
        top_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ===== hw/rtl/lpr_cell.sv =====
// One route table entry of the longest-prefix engine plus its beat stage.
// Compares the passing beat against its entry and hands the beat on through its beat register.
// Depends on lpr_pkg.
module lpr_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpr_pkg::t_beat i_beat,
    output lpr_pkg::t_beat o_beat
);

    logic           r_valid;
    logic [31:0]    r_prefix;
    logic [5:0]     r_len;
    logic           r_direct;
    logic [31:0]    r_hop;
    logic [2:0]     r_port;
    lpr_pkg::t_beat r_beat;

    lpr_pkg::t_beat n_beat;
    logic           n_write;
    logic           w_match;

    assign w_match = r_valid &&
                     (((i_beat.addr ^ r_prefix) & lpr_pkg::top_mask(r_len)) == 32'd0);

    always_comb begin
        n_beat  = i_beat;
        n_write = 1'b0;
        if (i_beat.vld) begin
            if (i_beat.op == lpr_pkg::OP_ADD) begin
                if (r_valid && r_prefix == i_beat.addr && r_len == i_beat.len) begin
                    n_beat.hit = 1'b1;
                end else if (!r_valid && !i_beat.hit && !i_beat.placed) begin
                    // first free slot, and no duplicate can sit beyond it
                    n_write       = 1'b1;
                    n_beat.placed = 1'b1;
                end
            end else begin
                // strictly longer wins, so the earlier entry keeps a tie
                if (w_match && (!i_beat.hit || r_len > i_beat.best_len)) begin
                    n_beat.hit         = 1'b1;
                    n_beat.best_len    = r_len;
                    n_beat.best_direct = r_direct;
                    n_beat.best_hop    = r_hop;
                    n_beat.best_port   = r_port;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_beat.vld <= 1'b0;
        end else begin
            if (n_write) begin
                r_valid <= 1'b1;
            end
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_write) begin
            r_prefix <= i_beat.addr;
            r_len    <= i_beat.len;
            r_direct <= ~i_beat.hop_given;
            r_hop    <= i_beat.hop;
            r_port   <= i_beat.port;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== hw/rtl/ipv4_longest_prefix_router.sv =====
// IPv4 longest-prefix route engine: a chain of ROUTES entry cells walked by one beat at a time.
// Items are taken one at a time: the beat visits one cell per cycle, and busy stays high until
// the result is loaded, so a new start is taken in the strobe cycle.
// Reset (synchronous, active low) empties the table and drops any beat in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ipv4_longest_prefix_router #(
    parameter int ROUTES     = lpr_pkg::LPR_ROUTES,
    parameter int INTERFACES = lpr_pkg::LPR_INTERFACES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [31:0] i_prefix_value,
    input  logic [5:0]  i_prefix_len,
    input  logic        i_hop_given,
    input  logic [31:0] i_hop_addr,
    input  logic [2:0]  i_out_port,
    input  logic [31:0] i_dst_addr,
    input  logic [7:0]  i_ttl_in,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [2:0]  o_egress_port,
    output logic [31:0] o_forward_addr,
    output logic [7:0]  o_ttl_out
);

    localparam logic [8:0] IF_N = 9'(INTERFACES);

    // Injection stage followed by one beat stage per cell.
    lpr_pkg::t_beat w_beat [ROUTES+1];
    logic [ROUTES:0] w_vld;

    lpr_pkg::t_beat r_inj;
    lpr_pkg::t_beat n_inj;
    logic           r_busy;
    logic           w_accept;

    logic [2:0]  w_port_mod;
    logic [5:0]  w_len_sat;

    logic        r_strobe;
    logic [2:0]  r_status;
    logic [2:0]  r_egress;
    logic [31:0] r_fwd;
    logic [7:0]  r_ttl;
    logic [2:0]  n_status;
    logic [2:0]  n_egress;
    logic [31:0] n_fwd;
    logic [7:0]  n_ttl;

    lpr_pkg::t_beat w_end;

    assign w_accept = start && !r_busy;

    // Reduce the interface index by repeated subtraction; at most seven steps for 3 bits.
    always_comb begin
        w_port_mod = i_out_port;
        for (int k = 0; k < 8; k++) begin
            if ({6'd0, w_port_mod} >= IF_N) begin
                w_port_mod = w_port_mod - IF_N[2:0];
            end
        end
    end

    // Lengths above 32 act as 32.
    assign w_len_sat = (i_prefix_len > 6'd32) ? 6'd32 : i_prefix_len;

    // Build the beat: the add carries the prefix, the route carries the destination.
    always_comb begin
        n_inj             = '0;
        n_inj.vld         = w_accept;
        n_inj.op          = i_op;
        n_inj.addr        = (i_op == lpr_pkg::OP_ADD) ? i_prefix_value : i_dst_addr;
        n_inj.len         = w_len_sat;
        n_inj.hop_given   = i_hop_given;
        n_inj.hop         = i_hop_addr;
        n_inj.port        = w_port_mod;
        n_inj.ttl         = i_ttl_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.vld <= 1'b0;
            r_busy    <= 1'b0;
        end else begin
            // load a fresh beat with cleared search fields, else drop the valid
            if (w_accept) begin
                r_inj <= n_inj;
            end else begin
                r_inj.vld <= 1'b0;
            end
            // hold busy from accept until the beat leaves the last cell
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_end.vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign w_beat[0] = r_inj;

    // Advance the beat one cell per cycle.
    for (genvar g = 0; g < ROUTES; g++) begin : g_cell
        lpr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g+1])
        );
    end

    for (genvar g = 0; g <= ROUTES; g++) begin : g_vld
        assign w_vld[g] = w_beat[g].vld;
    end

    assign w_end = w_beat[ROUTES];

    // Resolve the finished beat into a status and the forwarding fields.
    always_comb begin
        n_status = lpr_pkg::ST_ADDED;
        n_egress = 3'd0;
        n_fwd    = 32'd0;
        n_ttl    = 8'd0;
        if (w_end.op == lpr_pkg::OP_ADD) begin
            n_status = (w_end.hit || w_end.placed) ? lpr_pkg::ST_ADDED : lpr_pkg::ST_FULL;
        end else if (w_end.ttl <= 8'd1) begin
            // drop: TTL already zero or would reach zero here
            n_status = lpr_pkg::ST_TTL_EXP;
        end else if (!w_end.hit) begin
            n_status = lpr_pkg::ST_NO_ROUTE;
        end else begin
            n_status = lpr_pkg::ST_FORWARDED;
            n_egress = w_end.best_port;
            n_fwd    = w_end.best_direct ? w_end.addr : w_end.best_hop;
            n_ttl    = w_end.ttl - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_end.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end.vld) begin
            r_status <= n_status;
            r_egress <= n_egress;
            r_fwd    <= n_fwd;
            r_ttl    <= n_ttl;
        end
    end

    assign busy           = r_busy;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_egress_port  = r_egress;
    assign o_forward_addr = r_fwd;
    assign o_ttl_out      = r_ttl;

    // At most one beat walks the chain.
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one beat in the cell chain");

    // A result beat only comes once busy has dropped.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    // Busy drops only together with a result.
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("busy dropped without a result beat");

    // Non-forward results carry zero fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != lpr_pkg::ST_FORWARDED) |->
        (o_egress_port == 3'd0 && o_forward_addr == 32'd0 && o_ttl_out == 8'd0))
        else $error("non-forward result with nonzero fields");

    // A forwarded datagram always leaves with a live TTL.
    a_ttl_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == lpr_pkg::ST_FORWARDED) |-> o_ttl_out != 8'd0)
        else $error("forwarded datagram with zero TTL");

endmodule

// ===== bench/lpr_route_checker.sv =====
// Scoreboard for the IPv4 longest-prefix route engine: keeps its own copy of the route table,
// predicts the result of every accepted beat and compares it with the next strobed result.
// Depends on lpr_pkg for the op and status codes and the table size.
`timescale 1ns / 1ps

module lpr_route_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_op,
    input  logic [31:0] i_prefix_value,
    input  logic [5:0]  i_prefix_len,
    input  logic        i_hop_given,
    input  logic [31:0] i_hop_addr,
    input  logic [2:0]  i_out_port,
    input  logic [31:0] i_dst_addr,
    input  logic [7:0]  i_ttl_in,
    input  logic        i_strobe,
    input  logic [2:0]  i_status,
    input  logic [2:0]  i_egress_port,
    input  logic [31:0] i_forward_addr,
    input  logic [7:0]  i_ttl_out,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam int ROUTES     = lpr_pkg::LPR_ROUTES;
    localparam int INTERFACES = lpr_pkg::LPR_INTERFACES;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  port;
        logic [31:0] addr;
        logic [7:0]  ttl;
    } t_hop_decision;

    t_hop_decision decisions_due[$];

    logic        tbl_valid  [ROUTES];
    logic [31:0] tbl_prefix [ROUTES];
    logic [5:0]  tbl_len    [ROUTES];
    logic        tbl_direct [ROUTES];
    logic [31:0] tbl_hop    [ROUTES];
    logic [2:0]  tbl_port   [ROUTES];
    int          tbl_used;
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    // Apply one beat to the table copy and return the result it must produce.
    function automatic t_hop_decision decide_beat(
        input logic        op,
        input logic [31:0] pfx,
        input logic [5:0]  len,
        input logic        given,
        input logic [31:0] hop,
        input logic [2:0]  port,
        input logic [31:0] dst,
        input logic [7:0]  ttl
    );
        t_hop_decision res;
        logic [5:0]    sat_len;
        logic [31:0]   keep;
        logic          dup;
        int            best;
        int            k;
        res = '0;
        if (op == lpr_pkg::OP_ADD) begin
            sat_len = (len > 6'd32) ? 6'd32 : len;
            dup = 1'b0;
            for (k = 0; k < ROUTES; k++)
                if (tbl_valid[k] && tbl_prefix[k] == pfx && tbl_len[k] == sat_len)
                    dup = 1'b1;
            res.status = lpr_pkg::ST_ADDED;
            if (!dup && tbl_used >= ROUTES) begin
                res.status = lpr_pkg::ST_FULL;
            end else if (!dup) begin
                tbl_valid[tbl_used]  = 1'b1;
                tbl_prefix[tbl_used] = pfx;
                tbl_len[tbl_used]    = sat_len;
                tbl_direct[tbl_used] = !given;
                tbl_hop[tbl_used]    = hop;
                tbl_port[tbl_used]   = 3'(port % INTERFACES);
                tbl_used++;
            end
        end else if (ttl <= 8'd1) begin
            res.status = lpr_pkg::ST_TTL_EXP;
        end else begin
            best = -1;
            for (k = 0; k < ROUTES; k++) begin
                if (!tbl_valid[k])
                    continue;
                keep = (tbl_len[k] == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - tbl_len[k]));
                // strict compare keeps the earliest entry on a length tie
                if (((dst ^ tbl_prefix[k]) & keep) == 32'h0 &&
                    (best < 0 || tbl_len[k] > tbl_len[best]))
                    best = k;
            end
            if (best < 0) begin
                res.status = lpr_pkg::ST_NO_ROUTE;
            end else begin
                res.status = lpr_pkg::ST_FORWARDED;
                res.port   = tbl_port[best];
                res.addr   = tbl_direct[best] ? dst : tbl_hop[best];
                res.ttl    = ttl - 8'd1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_hop_decision want;
        if (!i_rst_n) begin
            for (int k = 0; k < ROUTES; k++)
                tbl_valid[k] = 1'b0;
            tbl_used = 0;
            decisions_due.delete();
            o_outstanding <= 0;
        end else begin
            // Retire the result before taking a new beat: a start can land in the strobe cycle.
            if (i_strobe) begin
                if (decisions_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, got status %0h",
                             $time, i_status);
                end else begin
                    want = decisions_due.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("egress_port", want.port, i_egress_port);
                    check_field("forward_addr", want.addr, i_forward_addr);
                    check_field("ttl_out", want.ttl, i_ttl_out);
                end
            end
            if (i_start && !i_busy)
                decisions_due.push_back(decide_beat(i_op, i_prefix_value, i_prefix_len,
                                                    i_hop_given, i_hop_addr, i_out_port,
                                                    i_dst_addr, i_ttl_in));
            o_outstanding <= decisions_due.size();
        end
    end

endmodule

// ===== bench/ipv4_longest_prefix_router_tb.sv =====
// Testbench top for the IPv4 longest-prefix route engine: drives add-route and datagram beats,
// and leaves prediction and comparison to lpr_route_checker. Depends on lpr_pkg and the RTL.
`timescale 1ns / 1ps

module ipv4_longest_prefix_router_tb;

    localparam int RANDOM_BEATS = 1330;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = lpr_pkg::LPR_ROUTES + 8;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_op           = lpr_pkg::OP_ADD;
    logic [31:0] i_prefix_value = '0;
    logic [5:0]  i_prefix_len   = '0;
    logic        i_hop_given    = 1'b0;
    logic [31:0] i_hop_addr     = '0;
    logic [2:0]  i_out_port     = '0;
    logic [31:0] i_dst_addr     = '0;
    logic [7:0]  i_ttl_in       = '0;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [2:0]  o_egress_port;
    logic [31:0] o_forward_addr;
    logic [7:0]  o_ttl_out;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    bit          gaps_on     = 1'b1;
    int          add_beats   = 0;
    int          route_beats = 0;

    // Prefixes offered so far; used only to aim destinations and duplicates at the table.
    logic [31:0] offered_pfx[$];
    logic [5:0]  offered_len[$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ipv4_longest_prefix_router DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_prefix_value (i_prefix_value),
        .i_prefix_len   (i_prefix_len),
        .i_hop_given    (i_hop_given),
        .i_hop_addr     (i_hop_addr),
        .i_out_port     (i_out_port),
        .i_dst_addr     (i_dst_addr),
        .i_ttl_in       (i_ttl_in),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_egress_port  (o_egress_port),
        .o_forward_addr (o_forward_addr),
        .o_ttl_out      (o_ttl_out)
    );

    lpr_route_checker route_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_prefix_value (i_prefix_value),
        .i_prefix_len   (i_prefix_len),
        .i_hop_given    (i_hop_given),
        .i_hop_addr     (i_hop_addr),
        .i_out_port     (i_out_port),
        .i_dst_addr     (i_dst_addr),
        .i_ttl_in       (i_ttl_in),
        .i_strobe       (o_strobe),
        .i_status       (o_status),
        .i_egress_port  (o_egress_port),
        .i_forward_addr (o_forward_addr),
        .i_ttl_out      (o_ttl_out),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // Drop the run if it hangs; the slowest clean run stays far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ipv4_longest_prefix_router_tb: done, errors");
            $finish;
        end
    end

    // Present one beat and hold it until the engine takes it. The optional gap either starts
    // right after the last accept or once busy has dropped, so it also lands on the strobe cycle
    // and on the idle cycles after it.
    task automatic issue_beat(input logic op, input logic [31:0] pfx, input logic [5:0] len,
                              input logic given, input logic [31:0] hop, input logic [2:0] port,
                              input logic [31:0] dst, input logic [7:0] ttl);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 0) begin
                @(posedge i_clk);
                while (busy) @(posedge i_clk);
            end
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_prefix_value <= pfx;
        i_prefix_len   <= len;
        i_hop_given    <= given;
        i_hop_addr     <= hop;
        i_out_port     <= port;
        i_dst_addr     <= dst;
        i_ttl_in       <= ttl;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Add a route; the datagram fields ride along with random content.
    task automatic install_route(input logic [31:0] pfx, input logic [5:0] len, input logic given,
                                 input logic [31:0] hop, input logic [2:0] port);
        offered_pfx.push_back(pfx);
        offered_len.push_back((len > 6'd32) ? 6'd32 : len);
        add_beats++;
        issue_beat(lpr_pkg::OP_ADD, pfx, len, given, hop, port, $urandom, 8'($urandom));
    endtask

    // Route one datagram; the add fields ride along with random content.
    task automatic route_datagram(input logic [31:0] dst, input logic [7:0] ttl);
        route_beats++;
        issue_beat(lpr_pkg::OP_ROUTE, $urandom, 6'($urandom), 1'($urandom), $urandom,
                   3'($urandom), dst, ttl);
    endtask

    // Lower start and hold until every expected result has come back.
    task automatic wait_for_results;
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin : stimulus
        int          pick;
        int          sel;
        logic [5:0]  len;
        logic [31:0] keep;
        logic [31:0] dst;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, expired TTL, ties, duplicates, saturation, extremes.
        route_datagram(32'h0A01_0203, 8'd9);                       // empty table: no route
        route_datagram(32'h0A01_0203, 8'd0);                       // TTL already zero
        route_datagram(32'h0A01_0203, 8'd1);                       // TTL hits zero here
        install_route(32'h0A00_0000, 6'd8, 1'b1, 32'hFFFF_FFFF, 3'd7);
        install_route(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 3'd2);
        install_route(32'h0A01_0203, 6'd63, 1'b0, 32'hDEAD_BEEF, 3'd5); // length saturates to 32
        install_route(32'h0AFF_0000, 6'd8, 1'b1, 32'h0101_0101, 3'd4);  // ties with the first /8
        install_route(32'h0A01_0000, 6'd16, 1'b1, 32'h0000_0000, 3'd0); // duplicate, ignored
        install_route(32'h0A01_0203, 6'd32, 1'b1, 32'h1111_1111, 3'd1); // duplicate once saturated
        install_route(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 3'd0);
        install_route(32'h0A01_0000, 6'd33, 1'b1, 32'h2222_2222, 3'd3); // new: /32, not the /16
        route_datagram(32'h0A01_0203, 8'd2);                       // /32 direct, TTL to 1
        route_datagram(32'h0A01_C807, 8'd255);                     // /16
        route_datagram(32'h0A4D_0001, 8'd64);                      // /8 tie: first added wins
        route_datagram(32'h0B00_0000, 8'd64);                      // no route
        route_datagram(32'hFFFF_FFFF, 8'd255);                     // all-ones host route
        route_datagram(32'h0000_0000, 8'd128);                     // no route
        route_datagram(32'h0A01_0203, 8'd1);                       // match, but TTL expires
        route_datagram(32'h0A01_0000, 8'd10);                      // host route from length 33
        install_route(32'h1234_5678, 6'd0, 1'b1, 32'h0000_0000, 3'd6);  // zero length: default
        route_datagram(32'h0000_0000, 8'd3);
        route_datagram(32'h8000_0000, 8'd200);
        route_datagram(32'h0A01_0204, 8'd10);                      // /16 over the default

        // Random part: mostly datagrams aimed at stored prefixes, with a steady trickle of
        // adds that fills the table, then runs into the full flag and duplicates.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            gaps_on = (n < RANDOM_BEATS * 85 / 100);
            if (n == RANDOM_BEATS / 2)
                wait_for_results();
            pick = $urandom_range(0, offered_pfx.size() - 1);
            sel  = $urandom_range(0, 99);
            if (sel < 12) begin
                if (sel < 3) begin
                    // exact duplicate, sometimes with an over-long length
                    len = offered_len[pick];
                    if (len == 6'd32 && $urandom_range(0, 1) == 1)
                        len = 6'($urandom_range(32, 63));
                    install_route(offered_pfx[pick], len, 1'($urandom), $urandom, 3'($urandom));
                end else if (sel < 5) begin
                    // same prefix bits, new length
                    install_route(offered_pfx[pick], 6'($urandom_range(0, 32)), 1'($urandom),
                                  $urandom, 3'($urandom));
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                      : 6'($urandom_range(1, 32));
                    install_route($urandom, len, 1'($urandom), $urandom, 3'($urandom));
                end
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    // keep the stored prefix bits, randomize the host part
                    len  = offered_len[pick];
                    keep = (len == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - len));
                    dst  = (offered_pfx[pick] & keep) | ($urandom & ~keep);
                end else begin
                    dst = $urandom;
                end
                route_datagram(dst, ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 1))
                                                                  : 8'($urandom_range(2, 255)));
            end
        end

        // Drain: wait out the last result, then give stray strobes time to show.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d add beats and %0d datagram beats: table fill, full table,",
                 add_beats, route_beats);
        $display("duplicates, length ties and saturation, default route, expired TTL.");
        if (fail_count == 0)
            $display("ipv4_longest_prefix_router_tb: done, clean");
        else
            $display("ipv4_longest_prefix_router_tb: done, errors");
        $finish;
    end

endmodule

// ===== ipv4_longest_prefix_router.f =====
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_cell.sv
hw/rtl/ipv4_longest_prefix_router.sv
bench/lpr_route_checker.sv
bench/ipv4_longest_prefix_router_tb.sv
